/* sv/rmbt_pkg.sv */
package rmbt_pkg;

  // Storage geometry
  localparam int DEPTH      = 1024;
  localparam int BLOCK_SIZE = 32;
  localparam int NUM_BLOCKS = (DEPTH + BLOCK_SIZE - 1) / BLOCK_SIZE;

  // Field widths
  localparam int POS_W  = 10;
  localparam int LEN_W  = 11;
  localparam int VAL_W  = 31;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NB_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int BLK_W  = $clog2(BLOCK_SIZE);

  localparam logic [VAL_W-1:0] IDENTITY = {VAL_W{1'b1}};

  // Action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_RESCAN,
    ST_QLEFT,
    ST_QMID,
    ST_QRIGHT,
    ST_DRAIN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
  } elem_req_t;

  typedef struct packed {
    logic             we;
    logic [NB_W-1:0]  waddr;
    logic [VAL_W-1:0] wdata;
    logic [NB_W-1:0]  raddr;
  } blk_req_t;

endpackage

/* sv/rmbt_if.sv */
interface rmbt_in_if import rmbt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [POS_W-1:0] position;
  logic [LEN_W-1:0] range_end;
  logic [VAL_W-1:0] value;

  modport source (output valid, action, position, range_end, value, input ready);
  modport sink   (input valid, action, position, range_end, value, output ready);
endinterface

interface rmbt_out_if import rmbt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] minimum;
  logic             empty_range;

  modport source (output valid, minimum, empty_range, input ready);
  modport sink   (input valid, minimum, empty_range, output ready);
endinterface

interface rmbt_cfg_if import rmbt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* sv/rmbt_ram.sv */
module rmbt_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/rmbt_ctrl.sv */
module rmbt_ctrl import rmbt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  rmbt_in_if.sink           in_ch,
  rmbt_out_if.source        out_ch,
  rmbt_cfg_if.sink          cfg_ch,
  output elem_req_t         elem_req,
  input  logic [VAL_W-1:0]  elem_q,
  output blk_req_t          blk_req,
  input  logic [VAL_W-1:0]  blk_q
);

  state_t           st_r, st_nxt;
  logic [LEN_W-1:0] ptr_r, ptr_nxt;
  logic [LEN_W-1:0] lim_r, lim_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] end_r, end_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [NB_W-1:0]  cl_r, cl_nxt;
  logic [NB_W-1:0]  cr_r, cr_nxt;
  logic             query_r, query_nxt;
  logic [VAL_W-1:0] acc_r, acc_nxt;
  logic             empty_r, empty_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic             rd_blk_r, rd_blk_nxt;
  logic [LEN_W-1:0] used_len_r, used_len_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic [VAL_W-1:0] out_min_r, out_min_nxt;
  logic             out_empty_r, out_empty_nxt;

  logic             in_acc;
  logic [LEN_W-1:0] end_clamp;
  logic [LEN_W-1:0] end_m1;
  logic [LEN_W-1:0] pos_ext;
  logic [NB_W-1:0]  in_cl;
  logic [NB_W-1:0]  in_cr;
  logic             q_empty;
  logic             wr_ok;
  logic [LEN_W-1:0] left_lim;
  logic [LEN_W-1:0] ptr_inc;
  logic             scan_last;
  logic             scanning;
  logic             mid_ok;
  logic [LEN_W-1:0] right_lo;
  logic [NB_W-1:0]  wr_blk;
  logic [LEN_W-1:0] resc_lo;
  logic [LEN_W-1:0] resc_hi;
  logic [VAL_W-1:0] rd_data;
  logic             out_free;

  // Handshakes
  assign in_ch.ready  = (st_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid       = out_vld_r;
  assign out_ch.minimum     = out_min_r;
  assign out_ch.empty_range = out_empty_r;
  assign out_free = !out_vld_r || out_ch.ready;

  // Decode of the incoming item
  assign pos_ext   = LEN_W'(in_ch.position);
  assign end_clamp = (in_ch.range_end > used_len_r) ? used_len_r : in_ch.range_end;
  assign end_m1    = end_clamp - LEN_W'(1);
  assign in_cl     = NB_W'(in_ch.position >> BLK_W);
  assign in_cr     = NB_W'(end_m1 >> BLK_W);
  assign q_empty   = (pos_ext >= end_clamp);
  assign wr_ok     = (pos_ext < used_len_r);
  assign left_lim  = (in_cl == in_cr) ? end_clamp
                                      : LEN_W'((LEN_W'(in_cl) + LEN_W'(1)) << BLK_W);

  // Scan bookkeeping
  assign ptr_inc   = ptr_r + LEN_W'(1);
  assign scan_last = (ptr_inc == lim_r);
  assign scanning  = (st_r == ST_RESCAN) || (st_r == ST_QLEFT) ||
                     (st_r == ST_QMID) || (st_r == ST_QRIGHT);
  assign mid_ok    = (LEN_W'(cr_r) > (LEN_W'(cl_r) + LEN_W'(1)));
  assign right_lo  = LEN_W'(LEN_W'(cr_r) << BLK_W);
  assign wr_blk    = NB_W'(pos_r >> BLK_W);
  assign resc_lo   = LEN_W'(LEN_W'(wr_blk) << BLK_W);
  assign resc_hi   = ((resc_lo + LEN_W'(BLOCK_SIZE)) > used_len_r) ? used_len_r
                                                               : (resc_lo + LEN_W'(BLOCK_SIZE));
  assign rd_data   = rd_blk_r ? blk_q : elem_q;

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLEAR: begin
        if (ptr_r == LEN_W'(DEPTH - 1)) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.action == ACT_QUERY) st_nxt = q_empty ? ST_FIN : ST_QLEFT;
          else if (wr_ok)                st_nxt = ST_WRITE;
        end
      end
      ST_WRITE:  st_nxt = ST_RESCAN;
      ST_RESCAN: begin
        if (scan_last) st_nxt = ST_DRAIN;
      end
      ST_QLEFT: begin
        if (scan_last) begin
          if (cl_r == cr_r) st_nxt = ST_DRAIN;
          else if (mid_ok)  st_nxt = ST_QMID;
          else              st_nxt = ST_QRIGHT;
        end
      end
      ST_QMID: begin
        if (scan_last) st_nxt = ST_QRIGHT;
      end
      ST_QRIGHT: begin
        if (scan_last) st_nxt = ST_DRAIN;
      end
      ST_DRAIN: st_nxt = ST_FIN;
      ST_FIN: begin
        if (!query_r || out_free) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory requests
  always_comb begin
    ptr_nxt       = ptr_r;
    lim_nxt       = lim_r;
    pos_nxt       = pos_r;
    end_nxt       = end_r;
    val_nxt       = val_r;
    cl_nxt        = cl_r;
    cr_nxt        = cr_r;
    query_nxt     = query_r;
    empty_nxt     = empty_r;
    acc_nxt       = acc_r;
    rd_vld_nxt    = scanning;
    rd_blk_nxt    = (st_r == ST_QMID);
    out_vld_nxt   = out_vld_r;
    out_min_nxt   = out_min_r;
    out_empty_nxt = out_empty_r;
    used_len_nxt  = used_len_r;

    elem_req.we    = 1'b0;
    elem_req.waddr = pos_r[ADDR_W-1:0];
    elem_req.wdata = val_r;
    elem_req.raddr = ptr_r[ADDR_W-1:0];
    blk_req.we     = 1'b0;
    blk_req.waddr  = wr_blk;
    blk_req.wdata  = acc_r;
    blk_req.raddr  = ptr_r[NB_W-1:0];

    // fold the word read last cycle
    if (rd_vld_r && (rd_data < acc_r)) acc_nxt = rd_data;

    unique case (st_r)
      ST_CLEAR: begin
        elem_req.we    = 1'b1;
        elem_req.waddr = ptr_r[ADDR_W-1:0];
        elem_req.wdata = IDENTITY;
        blk_req.we     = (ptr_r < LEN_W'(NUM_BLOCKS));
        blk_req.waddr  = ptr_r[NB_W-1:0];
        blk_req.wdata  = IDENTITY;
        ptr_nxt        = ptr_inc;
      end
      ST_IDLE: begin
        if (in_acc) begin
          pos_nxt   = in_ch.position;
          end_nxt   = end_clamp;
          val_nxt   = in_ch.value;
          cl_nxt    = in_cl;
          cr_nxt    = in_cr;
          query_nxt = (in_ch.action == ACT_QUERY);
          empty_nxt = q_empty;
          acc_nxt   = IDENTITY;
          ptr_nxt   = pos_ext;
          lim_nxt   = left_lim;
        end
      end
      ST_WRITE: begin
        elem_req.we = 1'b1;
        ptr_nxt     = resc_lo;
        lim_nxt     = resc_hi;
      end
      ST_RESCAN, ST_QRIGHT: begin
        ptr_nxt = ptr_inc;
      end
      ST_QLEFT: begin
        ptr_nxt = ptr_inc;
        if (scan_last) begin
          if (mid_ok) begin
            ptr_nxt = LEN_W'(cl_r) + LEN_W'(1);
            lim_nxt = LEN_W'(cr_r);
          end else begin
            ptr_nxt = right_lo;
            lim_nxt = end_r;
          end
        end
      end
      ST_QMID: begin
        ptr_nxt = ptr_inc;
        if (scan_last) begin
          ptr_nxt = right_lo;
          lim_nxt = end_r;
        end
      end
      ST_DRAIN: begin
      end
      ST_FIN: begin
        if (!query_r) begin
          blk_req.we = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // output register
    if (out_vld_r && out_ch.ready) out_vld_nxt = 1'b0;
    if ((st_r == ST_FIN) && query_r && out_free) begin
      out_vld_nxt   = 1'b1;
      out_min_nxt   = acc_r;
      out_empty_nxt = empty_r;
    end

    // length register, saturated to the store depth
    if (cfg_ch.valid) begin
      used_len_nxt = (cfg_ch.data > LEN_W'(DEPTH)) ? LEN_W'(DEPTH) : cfg_ch.data;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_CLEAR;
      ptr_r      <= '0;
      rd_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      used_len_r <= LEN_W'(DEPTH);
    end else begin
      st_r       <= st_nxt;
      ptr_r      <= ptr_nxt;
      rd_vld_r   <= rd_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      used_len_r <= used_len_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    lim_r       <= lim_nxt;
    pos_r       <= pos_nxt;
    end_r       <= end_nxt;
    val_r       <= val_nxt;
    cl_r        <= cl_nxt;
    cr_r        <= cr_nxt;
    query_r     <= query_nxt;
    empty_r     <= empty_nxt;
    acc_r       <= acc_nxt;
    rd_blk_r    <= rd_blk_nxt;
    out_min_r   <= out_min_nxt;
    out_empty_r <= out_empty_nxt;
  end

  // Checks
  a_scan_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    scanning |-> (ptr_r < lim_r))
    else $error("scan pointer past its limit");

  a_empty_identity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_empty_r) |-> (out_min_r == IDENTITY))
    else $error("empty range item without identity minimum");

  a_write_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_WRITE) |-> (LEN_W'(pos_r) < used_len_r))
    else $error("element write beyond used length");

  a_len_sat: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cfg_ch.valid) |-> (used_len_r <= LEN_W'(DEPTH)))
    else $error("used length above store depth");

endmodule

/* sv/range_minimum_block_table_unit.sv */
// Range-minimum table over a 1024-entry element store split into blocks of 32, with one
// stored minimum per block. Both live in single-port-read RAMs with a registered read port;
// every scan step is one RAM read, so that read port sets the rate. A write item stores its
// element, rereads each element of its block below the used length and then writes the new
// block minimum; a write at or beyond the used length is dropped. A query item reads each
// element of its partial end blocks and the stored minimum of each whole block between them;
// an empty range goes straight to its result. The block handles one item at a time; a
// finished result waits in an output register while the next item is taken. After reset a
// clearing pass fills both stores with 2^31-1 and no item is accepted during it; the length
// register can be written at any time the block is idle.
module range_minimum_block_table_unit import rmbt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  rmbt_in_if.sink     in_ch,
  rmbt_out_if.source  out_ch,
  rmbt_cfg_if.sink    cfg_ch
);

  elem_req_t        elem_req;
  blk_req_t         blk_req;
  logic [VAL_W-1:0] elem_q;
  logic [VAL_W-1:0] blk_q;

  // Sequencer and accumulator
  rmbt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_ch   (cfg_ch),
    .elem_req (elem_req),
    .elem_q   (elem_q),
    .blk_req  (blk_req),
    .blk_q    (blk_q)
  );

  // Element store
  rmbt_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_elem_ram (
    .clk   (clk),
    .we    (elem_req.we),
    .waddr (elem_req.waddr),
    .wdata (elem_req.wdata),
    .raddr (elem_req.raddr),
    .rdata (elem_q)
  );

  // Block minima
  rmbt_ram #(.WIDTH(VAL_W), .DEPTH(NUM_BLOCKS)) u_blk_ram (
    .clk   (clk),
    .we    (blk_req.we),
    .waddr (blk_req.waddr),
    .wdata (blk_req.wdata),
    .raddr (blk_req.raddr),
    .rdata (blk_q)
  );

endmodule

/* tb/rmbt_checker.sv */
`timescale 1ns / 1ps

// Watches the three channels, keeps its own copy of the element store, the block
// minima and the used length, and compares every result item with the oldest
// outstanding prediction.
module rmbt_checker import rmbt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  rmbt_in_if   in_ch,
  rmbt_out_if  out_ch,
  rmbt_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [VAL_W-1:0] minimum;
    logic             empty_range;
  } range_result_t;

  logic [VAL_W-1:0] element_copy [DEPTH];
  logic [VAL_W-1:0] block_min_copy [NUM_BLOCKS];
  int unsigned      length_copy;
  range_result_t    expected_minima [$];
  int               errors = 0;

  assign fail_count = errors;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // Recompute one block minimum; only indices below the used length count
  function automatic void rescan_block(int unsigned blk);
    int unsigned      lo;
    int unsigned      hi;
    logic [VAL_W-1:0] m;
    lo = blk * BLOCK_SIZE;
    hi = lo + BLOCK_SIZE;
    m  = IDENTITY;
    if (hi > length_copy) hi = length_copy;
    for (int unsigned i = lo; i < hi; i++)
      if (element_copy[i] < m) m = element_copy[i];
    block_min_copy[blk] = m;
  endfunction

  // Minimum over [first, stop): partial end blocks element-wise, whole blocks
  // from the stored (possibly stale) block minima
  function automatic range_result_t range_minimum(int unsigned first, int unsigned stop);
    range_result_t r;
    int unsigned   cl;
    int unsigned   cr;
    r.minimum     = IDENTITY;
    r.empty_range = 1'b0;
    if (stop > length_copy) stop = length_copy;
    if (first >= stop) begin
      r.empty_range = 1'b1;
      return r;
    end
    cl = first / BLOCK_SIZE;
    cr = (stop - 1) / BLOCK_SIZE;
    if (cl == cr) begin
      for (int unsigned i = first; i < stop; i++)
        if (element_copy[i] < r.minimum) r.minimum = element_copy[i];
    end else begin
      for (int unsigned i = first; i < (cl + 1) * BLOCK_SIZE; i++)
        if (element_copy[i] < r.minimum) r.minimum = element_copy[i];
      for (int unsigned b = cl + 1; b < cr; b++)
        if (block_min_copy[b] < r.minimum) r.minimum = block_min_copy[b];
      for (int unsigned i = cr * BLOCK_SIZE; i < stop; i++)
        if (element_copy[i] < r.minimum) r.minimum = element_copy[i];
    end
    return r;
  endfunction

  // Results are checked before the input item of the same edge is predicted
  always @(posedge clk) begin
    range_result_t got;
    range_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) element_copy[i] = IDENTITY;
      for (int i = 0; i < NUM_BLOCKS; i++) block_min_copy[i] = IDENTITY;
      length_copy = DEPTH;
      expected_minima.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.minimum     = out_ch.minimum;
        got.empty_range = out_ch.empty_range;
        if (expected_minima.size() == 0) begin
          report_mismatch($sformatf("result min=%0d empty=%0b with nothing outstanding",
                                    got.minimum, got.empty_range));
        end else begin
          want = expected_minima.pop_front();
          if (got.minimum !== want.minimum)
            report_mismatch($sformatf("minimum got %0d want %0d", got.minimum, want.minimum));
          if (got.empty_range !== want.empty_range)
            report_mismatch($sformatf("empty_range got %0b want %0b",
                                      got.empty_range, want.empty_range));
        end
      end

      // Length register saturates at the store depth
      if (cfg_ch.valid && cfg_ch.ready)
        length_copy = (cfg_ch.data > DEPTH) ? DEPTH : cfg_ch.data;

      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.action == ACT_WRITE) begin
          // writes at or beyond the used length are dropped
          if (in_ch.position < length_copy) begin
            element_copy[in_ch.position] = in_ch.value;
            rescan_block(in_ch.position / BLOCK_SIZE);
          end
        end else begin
          expected_minima.push_back(range_minimum(in_ch.position, in_ch.range_end));
        end
      end
    end
    pending <= expected_minima.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import rmbt_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 48;
  localparam int DRAIN_CYCLES  = 120;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        calm = 1'b0;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int unsigned active_length = DEPTH;

  rmbt_in_if  in_ch ();
  rmbt_out_if out_ch ();
  rmbt_cfg_if cfg_ch ();

  range_minimum_block_table_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  rmbt_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side back-pressure: random stalls, none once calm
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm) begin
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 12);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // One input item, with an occasional gap in front of it
  task automatic send_item(input logic act, input logic [POS_W-1:0] pos,
                           input logic [LEN_W-1:0] stop, input logic [VAL_W-1:0] val);
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.position  <= pos;
    in_ch.range_end <= stop;
    in_ch.value     <= val;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid, wait for every outstanding result, then let a trailing write finish
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_length(input int unsigned len);
    wait_idle();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= len[LEN_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    active_length = (len > DEPTH) ? DEPTH : len;
  endtask

  // Mostly in-range writes and well-formed queries, the rest raw noise
  task automatic run_random(input int count);
    int unsigned      sel;
    int unsigned      first;
    int unsigned      stop;
    int unsigned      span;
    logic [31:0]      noise_pos;
    logic [31:0]      noise_end;
    logic [VAL_W-1:0] val;
    repeat (count) begin
      sel       = $urandom_range(0, 99);
      noise_pos = $urandom;
      noise_end = $urandom;
      case ($urandom_range(0, 3))
        0:       val = VAL_W'($urandom_range(0, 4095));
        1:       val = VAL_W'($urandom);
        2:       val = sel[0] ? '0 : IDENTITY;
        default: val = VAL_W'($urandom_range(0, 1 << 20));
      endcase
      if (active_length == 0 || sel >= 92) begin
        send_item(sel[0] ? ACT_QUERY : ACT_WRITE, noise_pos[POS_W-1:0],
                  noise_end[LEN_W-1:0], val);
      end else if (sel < 40) begin
        first = (sel < 37) ? $urandom_range(0, active_length - 1) : $urandom_range(0, DEPTH - 1);
        send_item(ACT_WRITE, first[POS_W-1:0], noise_end[LEN_W-1:0], val);
      end else begin
        first = $urandom_range(0, active_length - 1);
        if (sel < 65) span = $urandom_range(1, BLOCK_SIZE);
        else          span = $urandom_range(1, active_length - first);
        stop = first + span;
        if (stop > active_length) stop = active_length;
        send_item(ACT_QUERY, first[POS_W-1:0], stop[LEN_W-1:0], val);
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.action    = ACT_WRITE;
    in_ch.position  = '0;
    in_ch.range_end = '0;
    in_ch.value     = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    set_length(DEPTH);

    // Directed: fresh store, field extremes, clamping and empty ranges
    send_item(ACT_QUERY, 10'd0, 11'd1024, '0);
    send_item(ACT_WRITE, 10'd0, 11'd0, '0);
    send_item(ACT_WRITE, 10'd1023, 11'd2047, IDENTITY);
    send_item(ACT_WRITE, 10'd45, 11'd0, 31'd5);
    send_item(ACT_WRITE, 10'd33, 11'd0, 31'd9);
    send_item(ACT_QUERY, 10'd0, 11'd0, '0);
    send_item(ACT_QUERY, 10'd1023, 11'd2047, '0);
    send_item(ACT_QUERY, 10'd512, 11'd100, '0);
    send_item(ACT_QUERY, 10'd1, 11'd32, '0);
    send_item(ACT_QUERY, 10'd0, 11'd1024, '0);
    send_item(ACT_QUERY, 10'd33, 11'd46, '0);
    send_item(ACT_WRITE, 10'd500, 11'd0, 31'd77);
    send_item(ACT_QUERY, 10'd100, 11'd1000, IDENTITY);

    // Short length: write beyond it dropped, block rescan stops at it
    set_length(40);
    send_item(ACT_WRITE, 10'd50, 11'd0, 31'd1);
    send_item(ACT_WRITE, 10'd33, 11'd0, 31'd8);
    send_item(ACT_QUERY, 10'd1, 11'd2047, '0);
    send_item(ACT_QUERY, 10'd40, 11'd41, '0);

    // Length back up: block 1 as a whole block keeps its stale minimum
    set_length(DEPTH);
    send_item(ACT_QUERY, 10'd1, 11'd100, '0);
    send_item(ACT_QUERY, 10'd50, 11'd60, '0);
    send_item(ACT_QUERY, 10'd32, 11'd64, '0);

    // Zero length: everything ignored or empty
    set_length(0);
    send_item(ACT_WRITE, 10'd10, 11'd0, 31'd3);
    send_item(ACT_QUERY, 10'd0, 11'd1024, '0);

    // Oversized length saturates at the depth
    set_length(2047);
    send_item(ACT_QUERY, 10'd0, 11'd2047, '0);

    // Random phases across several lengths
    run_random(300);
    set_length($urandom_range(2, DEPTH - 1));
    run_random(200);
    set_length(2047);
    run_random(150);
    set_length(1);
    run_random(50);
    set_length(0);
    run_random(20);
    set_length(DEPTH);
    calm = 1'b1;
    run_random(230);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

/* filelist.f */
sv/rmbt_pkg.sv
sv/rmbt_if.sv
sv/rmbt_ram.sv
sv/rmbt_ctrl.sv
sv/range_minimum_block_table_unit.sv
tb/rmbt_checker.sv
tb/tb.sv
